// File: rtl/core/assert_macros.svh
// Assertion macros shared by the alignment unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DPBA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the following cycle.
`define DPBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/dpba_pkg.sv
// Shared types, widths and constants of the dual PID base alignment unit.
package dpba_pkg;

    // Fixed point widths (Q3.12 data, Q4.12 gains)
    localparam int FRAC_W  = 12;
    localparam int DATA_W  = 16;
    localparam int LIM_W   = 15;
    localparam int GAIN_W  = 16;
    localparam int ERR_W   = 17;
    localparam int ACC_W   = ERR_W + 1;
    localparam int DER_W   = 18;
    localparam int INT_W   = 10;
    localparam int PRD_P_W = ERR_W + GAIN_W + 1;
    localparam int PRD_I_W = INT_W + GAIN_W + 1;
    localparam int PRD_D_W = DER_W + GAIN_W + 1;
    localparam int SUM_W   = 37;
    localparam int RND_W   = SUM_W - FRAC_W;
    localparam int STAGES  = 4;
    localparam int CFG_W   = 64;
    localparam int ADDR_W  = 6;
    localparam int GAINS_W = 48;

    // Integrator limit of +-0.1
    localparam logic signed [INT_W-1:0] INT_MAX = 10'sd410;
    localparam logic signed [INT_W-1:0] INT_MIN = -10'sd410;

    // Rounding offsets, ties away from zero
    localparam logic signed [SUM_W-1:0] RND_HALF_POS = 37'sd2048;
    localparam logic signed [SUM_W-1:0] RND_HALF_NEG = 37'sd2047;

    // Configuration register map
    typedef enum logic [2:0] {
        REG_TARGET_DISTANCE    = 3'd0,
        REG_LINEAR_GAINS       = 3'd1,
        REG_ANGULAR_GAINS      = 3'd2,
        REG_MAX_LINEAR         = 3'd3,
        REG_MAX_ANGULAR        = 3'd4,
        REG_AXIS_MODE          = 3'd5,
        REG_DISTANCE_TOLERANCE = 3'd6,
        REG_SLOPE_TOLERANCE    = 3'd7
    } reg_idx_t;

    // Sensor axis routing of the linear drive
    typedef enum logic [1:0] {
        AXIS_POS_X = 2'd0,
        AXIS_NEG_X = 2'd1,
        AXIS_POS_Y = 2'd2,
        AXIS_NEG_Y = 2'd3
    } axis_t;

    // Item kinds
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_MEASURE = 1'b1;

    // Register reset values
    localparam logic [LIM_W-1:0]   RST_TARGET   = 15'd205;
    localparam logic [GAINS_W-1:0] RST_LIN_GAIN = 48'd3277;
    localparam logic [GAINS_W-1:0] RST_ANG_GAIN = 48'd2048;
    localparam logic [LIM_W-1:0]   RST_MAX_LIN  = 15'd307;
    localparam logic [LIM_W-1:0]   RST_MAX_ANG  = 15'd410;
    localparam logic [LIM_W-1:0]   RST_DIST_TOL = 15'd164;
    localparam logic [LIM_W-1:0]   RST_SLOPE_TOL = 15'd164;

    // Pipeline control handed to each PID lane
    typedef struct packed {
        logic              accept;
        logic              start;
        logic [STAGES-1:0] go;
    } lane_ctrl_t;

    // Saturate a rounded drive to +-lim and narrow it to the port width
    function automatic logic signed [DATA_W-1:0] sat_drive(
        input logic signed [RND_W-1:0] v,
        input logic [LIM_W-1:0]        lim
    );
        logic signed [RND_W-1:0] lim_pos;
        logic signed [RND_W-1:0] lim_neg;
        logic signed [RND_W-1:0] res;
        lim_pos = $signed({{(RND_W-LIM_W){1'b0}}, lim});
        lim_neg = -lim_pos;
        if (v > lim_pos)
        begin
            res = lim_pos;
        end
        else if (v < lim_neg)
        begin
            res = lim_neg;
        end
        else
        begin
            res = v;
        end
        return res[DATA_W-1:0];
    endfunction

endpackage

// File: rtl/core/dpba_pid_lane.sv
// One PID loop: integrator and last error state, products, sum and rounding.
`include "assert_macros.svh"

module dpba_pid_lane (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dpba_pkg::lane_ctrl_t                 ctrl,
    input  logic signed [dpba_pkg::ERR_W-1:0]    err,
    input  logic [dpba_pkg::GAINS_W-1:0]         gains,
    output logic signed [dpba_pkg::RND_W-1:0]    rounded
);

    // Loop state
    logic signed [dpba_pkg::INT_W-1:0]   integ_reg;
    logic signed [dpba_pkg::INT_W-1:0]   integ_next;
    logic signed [dpba_pkg::ERR_W-1:0]   prev_reg;
    logic signed [dpba_pkg::ERR_W-1:0]   prev_next;

    // Input stage terms
    logic signed [dpba_pkg::ACC_W-1:0]   integ_sum;
    logic signed [dpba_pkg::INT_W-1:0]   integ_clamp;
    logic signed [dpba_pkg::DER_W-1:0]   deriv;
    logic signed [dpba_pkg::ERR_W-1:0]   err_a_reg;
    logic signed [dpba_pkg::INT_W-1:0]   integ_a_reg;
    logic signed [dpba_pkg::DER_W-1:0]   deriv_a_reg;

    // Products
    logic signed [dpba_pkg::GAIN_W:0]    kp_s;
    logic signed [dpba_pkg::GAIN_W:0]    ki_s;
    logic signed [dpba_pkg::GAIN_W:0]    kd_s;
    logic signed [dpba_pkg::PRD_P_W-1:0] prd_p;
    logic signed [dpba_pkg::PRD_I_W-1:0] prd_i;
    logic signed [dpba_pkg::PRD_D_W-1:0] prd_d;
    logic signed [dpba_pkg::PRD_P_W-1:0] prd_p_reg;
    logic signed [dpba_pkg::PRD_I_W-1:0] prd_i_reg;
    logic signed [dpba_pkg::PRD_D_W-1:0] prd_d_reg;

    // Sum and rounding
    logic signed [dpba_pkg::SUM_W-1:0]   sum_c;
    logic signed [dpba_pkg::SUM_W-1:0]   sum_reg;
    logic signed [dpba_pkg::SUM_W-1:0]   sum_ofs;
    logic signed [dpba_pkg::RND_W-1:0]   rnd_reg;

    // Integrate with clamp, form derivative against the last error
    always_comb
    begin
        integ_sum = dpba_pkg::ACC_W'(integ_reg) + dpba_pkg::ACC_W'(err);
        if (integ_sum > dpba_pkg::ACC_W'(dpba_pkg::INT_MAX))
        begin
            integ_clamp = dpba_pkg::INT_MAX;
        end
        else if (integ_sum < dpba_pkg::ACC_W'(dpba_pkg::INT_MIN))
        begin
            integ_clamp = dpba_pkg::INT_MIN;
        end
        else
        begin
            integ_clamp = integ_sum[dpba_pkg::INT_W-1:0];
        end
        deriv = dpba_pkg::DER_W'(err) - dpba_pkg::DER_W'(prev_reg);
        integ_next = ctrl.start ? '0 : integ_clamp;
        prev_next  = ctrl.start ? '0 : err;
    end

    // Update the loop state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
            prev_reg  <= '0;
        end
        else if (ctrl.accept)
        begin
            integ_reg <= integ_next;
            prev_reg  <= prev_next;
        end
    end

    // Unpack gains as non-negative signed operands
    assign kp_s = $signed({1'b0, gains[15:0]});
    assign ki_s = $signed({1'b0, gains[31:16]});
    assign kd_s = $signed({1'b0, gains[47:32]});

    assign prd_p = err_a_reg * kp_s;
    assign prd_i = integ_a_reg * ki_s;
    assign prd_d = deriv_a_reg * kd_s;

    assign sum_c = dpba_pkg::SUM_W'(prd_p_reg) + dpba_pkg::SUM_W'(prd_i_reg)
                 + dpba_pkg::SUM_W'(prd_d_reg);

    // Round to nearest, ties away from zero, by a biased arithmetic shift
    assign sum_ofs = sum_reg + (sum_reg[dpba_pkg::SUM_W-1] ? dpba_pkg::RND_HALF_NEG
                                                         : dpba_pkg::RND_HALF_POS);

    // Advance the pipeline stages
    always_ff @(posedge clk)
    begin
        if (ctrl.go[0])
        begin
            err_a_reg   <= err;
            integ_a_reg <= integ_next;
            deriv_a_reg <= deriv;
        end
        if (ctrl.go[1])
        begin
            prd_p_reg <= prd_p;
            prd_i_reg <= prd_i;
            prd_d_reg <= prd_d;
        end
        if (ctrl.go[2])
        begin
            sum_reg <= sum_c;
        end
        if (ctrl.go[3])
        begin
            rnd_reg <= sum_ofs[dpba_pkg::SUM_W-1:dpba_pkg::FRAC_W];
        end
    end

    assign rounded = rnd_reg;

    `DPBA_ASSERT(a_integ_bounded, (integ_reg <= dpba_pkg::INT_MAX) && (integ_reg >= dpba_pkg::INT_MIN), "integrator left its clamp range")
    `DPBA_ASSERT_NEXT(a_start_clears, ctrl.accept && ctrl.start, (integ_reg == '0) && (prev_reg == '0), "start transaction did not clear loop state")

endmodule

// File: rtl/core/dual_pid_base_alignment_unit.sv
// Top level of the dual PID base alignment unit: config port, pipeline and output.
// An accepted input passes the input, product, sum and rounding stages, then the output register.
// Throughput: one transaction per cycle while the output is not stalled; the integrator
// and last error update at the input stage is the only loop.
// Stalls hold each pipeline stage; bubbles close up behind a stalled output.
// Reset: registers take their defaults, loop state clears, the pipeline empties.
`include "assert_macros.svh"

module dual_pid_base_alignment_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dpba_pkg::ADDR_W-1:0]         paddr,
    input  logic [dpba_pkg::CFG_W-1:0]          pwdata,
    output logic [dpba_pkg::CFG_W-1:0]          prdata,
    output logic                                pready,
    // Input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                kind,
    input  logic signed [dpba_pkg::DATA_W-1:0]  distance,
    input  logic signed [dpba_pkg::DATA_W-1:0]  slope,
    // Output channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [dpba_pkg::DATA_W-1:0]  drive_x,
    output logic signed [dpba_pkg::DATA_W-1:0]  drive_y,
    output logic signed [dpba_pkg::DATA_W-1:0]  turn_rate,
    output logic                                reached
);

    // Configuration registers
    logic [dpba_pkg::LIM_W-1:0]    target_reg;
    logic [dpba_pkg::GAINS_W-1:0]  lin_gain_reg;
    logic [dpba_pkg::GAINS_W-1:0]  ang_gain_reg;
    logic [dpba_pkg::LIM_W-1:0]    max_lin_reg;
    logic [dpba_pkg::LIM_W-1:0]    max_ang_reg;
    dpba_pkg::axis_t               axis_reg;
    logic [dpba_pkg::LIM_W-1:0]    dist_tol_reg;
    logic [dpba_pkg::LIM_W-1:0]    slope_tol_reg;
    dpba_pkg::reg_idx_t            reg_idx;
    logic                          cfg_write;

    // Input stage
    logic                          accept;
    logic signed [dpba_pkg::ERR_W-1:0] slope_ext;
    logic signed [dpba_pkg::ERR_W-1:0] ang_err;
    logic signed [dpba_pkg::ERR_W-1:0] lin_err;
    logic [dpba_pkg::ERR_W-1:0]    abs_lin;
    logic [dpba_pkg::ERR_W-1:0]    abs_slope;
    logic                          reached_in;

    // Pipeline control
    logic [dpba_pkg::STAGES-1:0]   v_reg;
    logic [dpba_pkg::STAGES-1:0]   kind_pipe_reg;
    logic [dpba_pkg::STAGES-1:0]   reach_pipe_reg;
    logic [dpba_pkg::STAGES-1:0]   go;
    logic                          go_out;
    dpba_pkg::lane_ctrl_t          lane_ctrl;

    // Lane results and output stage
    logic signed [dpba_pkg::RND_W-1:0]  ang_rnd;
    logic signed [dpba_pkg::RND_W-1:0]  lin_rnd;
    logic signed [dpba_pkg::RND_W-1:0]  lin_signed;
    logic signed [dpba_pkg::DATA_W-1:0] lin_sat;
    logic signed [dpba_pkg::DATA_W-1:0] drive_x_next;
    logic signed [dpba_pkg::DATA_W-1:0] drive_y_next;
    logic signed [dpba_pkg::DATA_W-1:0] turn_next;
    logic                               reached_next;
    logic                               out_valid_reg;
    logic signed [dpba_pkg::DATA_W-1:0] drive_x_reg;
    logic signed [dpba_pkg::DATA_W-1:0] drive_y_reg;
    logic signed [dpba_pkg::DATA_W-1:0] turn_reg;
    logic                               reached_reg;

    // Decode configuration writes
    assign pready    = 1'b1;
    assign reg_idx   = dpba_pkg::reg_idx_t'(paddr[dpba_pkg::ADDR_W-1:3]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= dpba_pkg::RST_TARGET;
            lin_gain_reg  <= dpba_pkg::RST_LIN_GAIN;
            ang_gain_reg  <= dpba_pkg::RST_ANG_GAIN;
            max_lin_reg   <= dpba_pkg::RST_MAX_LIN;
            max_ang_reg   <= dpba_pkg::RST_MAX_ANG;
            axis_reg      <= dpba_pkg::AXIS_POS_X;
            dist_tol_reg  <= dpba_pkg::RST_DIST_TOL;
            slope_tol_reg <= dpba_pkg::RST_SLOPE_TOL;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                dpba_pkg::REG_TARGET_DISTANCE:    target_reg    <= pwdata[dpba_pkg::LIM_W-1:0];
                dpba_pkg::REG_LINEAR_GAINS:       lin_gain_reg  <= pwdata[dpba_pkg::GAINS_W-1:0];
                dpba_pkg::REG_ANGULAR_GAINS:      ang_gain_reg  <= pwdata[dpba_pkg::GAINS_W-1:0];
                dpba_pkg::REG_MAX_LINEAR:         max_lin_reg   <= pwdata[dpba_pkg::LIM_W-1:0];
                dpba_pkg::REG_MAX_ANGULAR:        max_ang_reg   <= pwdata[dpba_pkg::LIM_W-1:0];
                dpba_pkg::REG_AXIS_MODE:          axis_reg      <= dpba_pkg::axis_t'(pwdata[1:0]);
                dpba_pkg::REG_DISTANCE_TOLERANCE: dist_tol_reg  <= pwdata[dpba_pkg::LIM_W-1:0];
                dpba_pkg::REG_SLOPE_TOLERANCE:    slope_tol_reg <= pwdata[dpba_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Return register contents on reads
    always_comb
    begin
        case (reg_idx)
            dpba_pkg::REG_TARGET_DISTANCE:    prdata = dpba_pkg::CFG_W'(target_reg);
            dpba_pkg::REG_LINEAR_GAINS:       prdata = dpba_pkg::CFG_W'(lin_gain_reg);
            dpba_pkg::REG_ANGULAR_GAINS:      prdata = dpba_pkg::CFG_W'(ang_gain_reg);
            dpba_pkg::REG_MAX_LINEAR:         prdata = dpba_pkg::CFG_W'(max_lin_reg);
            dpba_pkg::REG_MAX_ANGULAR:        prdata = dpba_pkg::CFG_W'(max_ang_reg);
            dpba_pkg::REG_AXIS_MODE:          prdata = dpba_pkg::CFG_W'(axis_reg);
            dpba_pkg::REG_DISTANCE_TOLERANCE: prdata = dpba_pkg::CFG_W'(dist_tol_reg);
            dpba_pkg::REG_SLOPE_TOLERANCE:    prdata = dpba_pkg::CFG_W'(slope_tol_reg);
            default:                          prdata = '0;
        endcase
    end

    // Form errors and the reached test at the input
    always_comb
    begin
        slope_ext  = dpba_pkg::ERR_W'(slope);
        ang_err    = -slope_ext;
        lin_err    = dpba_pkg::ERR_W'(distance) - $signed({2'b00, target_reg});
        abs_lin    = lin_err[dpba_pkg::ERR_W-1] ? $unsigned(-lin_err) : $unsigned(lin_err);
        abs_slope  = slope_ext[dpba_pkg::ERR_W-1] ? $unsigned(-slope_ext)
                                                  : $unsigned(slope_ext);
        reached_in = (abs_lin < {2'b00, dist_tol_reg}) && (abs_slope < {2'b00, slope_tol_reg});
    end

    // Advance a stage when it is empty or its successor advances
    always_comb
    begin
        go_out = !out_valid_reg || out_ready;
        go[dpba_pkg::STAGES-1] = !v_reg[dpba_pkg::STAGES-1] || go_out;
        for (int k = dpba_pkg::STAGES - 2; k >= 0; k--)
        begin
            go[k] = !v_reg[k] || go[k+1];
        end
    end

    assign in_ready = go[0];
    assign accept   = in_valid && in_ready;

    assign lane_ctrl.accept = accept;
    assign lane_ctrl.start  = (kind == dpba_pkg::KIND_START);
    assign lane_ctrl.go     = go;

    // Track valid bits through the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (go[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < dpba_pkg::STAGES; k++)
            begin
                if (go[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
            if (go_out)
            begin
                out_valid_reg <= v_reg[dpba_pkg::STAGES-1];
            end
        end
    end

    // Carry kind and reached alongside the lanes
    always_ff @(posedge clk)
    begin
        if (go[0])
        begin
            kind_pipe_reg[0]  <= kind;
            reach_pipe_reg[0] <= reached_in;
        end
        for (int k = 1; k < dpba_pkg::STAGES; k++)
        begin
            if (go[k])
            begin
                kind_pipe_reg[k]  <= kind_pipe_reg[k-1];
                reach_pipe_reg[k] <= reach_pipe_reg[k-1];
            end
        end
    end

    dpba_pid_lane u_ang_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lane_ctrl),
        .err     (ang_err),
        .gains   (ang_gain_reg),
        .rounded (ang_rnd)
    );

    dpba_pid_lane u_lin_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lane_ctrl),
        .err     (lin_err),
        .gains   (lin_gain_reg),
        .rounded (lin_rnd)
    );

    // Negate, route and saturate the drives
    always_comb
    begin
        if ((axis_reg == dpba_pkg::AXIS_NEG_X) || (axis_reg == dpba_pkg::AXIS_NEG_Y))
        begin
            lin_signed = -lin_rnd;
        end
        else
        begin
            lin_signed = lin_rnd;
        end
        lin_sat      = dpba_pkg::sat_drive(lin_signed, max_lin_reg);
        turn_next    = dpba_pkg::sat_drive(-ang_rnd, max_ang_reg);
        drive_x_next = '0;
        drive_y_next = '0;
        case (axis_reg)
            dpba_pkg::AXIS_POS_X, dpba_pkg::AXIS_NEG_X: drive_x_next = lin_sat;
            dpba_pkg::AXIS_POS_Y, dpba_pkg::AXIS_NEG_Y: drive_y_next = lin_sat;
            default: ;
        endcase
        reached_next = reach_pipe_reg[dpba_pkg::STAGES-1];
        // Drop everything to zero for a start transaction
        if (kind_pipe_reg[dpba_pkg::STAGES-1] == dpba_pkg::KIND_START)
        begin
            drive_x_next = '0;
            drive_y_next = '0;
            turn_next    = '0;
            reached_next = 1'b0;
        end
    end

    // Hold the result until the output transaction completes
    always_ff @(posedge clk)
    begin
        if (go_out)
        begin
            drive_x_reg <= drive_x_next;
            drive_y_reg <= drive_y_next;
            turn_reg    <= turn_next;
            reached_reg <= reached_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive_x   = drive_x_reg;
    assign drive_y   = drive_y_reg;
    assign turn_rate = turn_reg;
    assign reached   = reached_reg;

    `DPBA_ASSERT(a_one_axis, !out_valid_reg || (drive_x_reg == '0) || (drive_y_reg == '0), "both linear axes driven")
    `DPBA_ASSERT(a_turn_bounded, !out_valid_reg || ((turn_reg <= $signed({1'b0, max_ang_reg})) && (turn_reg >= -$signed({1'b0, max_ang_reg}))), "turn rate beyond saturation limit")
    `DPBA_ASSERT(a_ready_stall, in_ready || v_reg[0], "input stalled while first stage empty")

endmodule

// File: test/dual_pid_base_alignment_unit_tb.sv
// Self-checking testbench for the dual PID base alignment unit.
module dual_pid_base_alignment_unit_tb;

    localparam int IDLE_LIMIT   = 2000;
    localparam int MAX_GAP      = 17;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 10;
    localparam int BURST_LEN    = 75;
    localparam int NUM_PHASES   = 10;

    // One drive command as seen on the output channel
    typedef struct packed {
        logic signed [dpba_pkg::DATA_W-1:0] dx;
        logic signed [dpba_pkg::DATA_W-1:0] dy;
        logic signed [dpba_pkg::DATA_W-1:0] turn;
        logic                               reached;
    } drive_cmd_t;

    // Alignment predictor and queue of pending drive commands
    class align_scoreboard;
        logic [dpba_pkg::LIM_W-1:0]   target_dist;
        logic [dpba_pkg::GAINS_W-1:0] lin_gains;
        logic [dpba_pkg::GAINS_W-1:0] ang_gains;
        logic [dpba_pkg::LIM_W-1:0]   max_lin;
        logic [dpba_pkg::LIM_W-1:0]   max_ang;
        dpba_pkg::axis_t              axis;
        logic [dpba_pkg::LIM_W-1:0]   dist_tol;
        logic [dpba_pkg::LIM_W-1:0]   slope_tol;
        longint                       ang_integ;
        longint                       dist_integ;
        longint                       ang_last;
        longint                       dist_last;
        drive_cmd_t                   pending[$];
        int                           mismatches;
        bit                           failed;

        function new();
            target_dist = dpba_pkg::RST_TARGET;
            lin_gains   = dpba_pkg::RST_LIN_GAIN;
            ang_gains   = dpba_pkg::RST_ANG_GAIN;
            max_lin     = dpba_pkg::RST_MAX_LIN;
            max_ang     = dpba_pkg::RST_MAX_ANG;
            axis        = dpba_pkg::AXIS_POS_X;
            dist_tol    = dpba_pkg::RST_DIST_TOL;
            slope_tol   = dpba_pkg::RST_SLOPE_TOL;
            ang_integ   = 0;
            dist_integ  = 0;
            ang_last    = 0;
            dist_last   = 0;
            mismatches  = 0;
            failed      = 0;
        endfunction

        // Mirror a register write, keeping only the register's width
        function void write_reg(dpba_pkg::reg_idx_t idx, logic [dpba_pkg::CFG_W-1:0] v);
            case (idx)
                dpba_pkg::REG_TARGET_DISTANCE:    target_dist = v[dpba_pkg::LIM_W-1:0];
                dpba_pkg::REG_LINEAR_GAINS:       lin_gains   = v[dpba_pkg::GAINS_W-1:0];
                dpba_pkg::REG_ANGULAR_GAINS:      ang_gains   = v[dpba_pkg::GAINS_W-1:0];
                dpba_pkg::REG_MAX_LINEAR:         max_lin     = v[dpba_pkg::LIM_W-1:0];
                dpba_pkg::REG_MAX_ANGULAR:        max_ang     = v[dpba_pkg::LIM_W-1:0];
                dpba_pkg::REG_AXIS_MODE:          axis        = dpba_pkg::axis_t'(v[1:0]);
                dpba_pkg::REG_DISTANCE_TOLERANCE: dist_tol    = v[dpba_pkg::LIM_W-1:0];
                dpba_pkg::REG_SLOPE_TOLERANCE:    slope_tol   = v[dpba_pkg::LIM_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clamp(longint v, longint lim);
            if (v > lim)
            begin
                return lim;
            end
            if (v < -lim)
            begin
                return -lim;
            end
            return v;
        endfunction

        // One PID update: clamped integrator, first difference, rounded Q.12 sum
        function longint pid_update(longint err, inout longint integ, inout longint last,
                                    input logic [dpba_pkg::GAINS_W-1:0] g);
            longint deriv;
            longint acc;
            longint mag;
            integ = clamp(integ + err, longint'(dpba_pkg::INT_MAX));
            deriv = err - last;
            last  = err;
            acc   = err * longint'(g[15:0]) + integ * longint'(g[31:16])
                  + deriv * longint'(g[47:32]);
            mag   = ((acc < 0 ? -acc : acc) + 2048) / 4096;
            return (acc < 0) ? -mag : mag;
        endfunction

        // Note an accepted transaction and queue the drive command it causes
        function void note_input(logic k, logic signed [dpba_pkg::DATA_W-1:0] d,
                                 logic signed [dpba_pkg::DATA_W-1:0] s);
            drive_cmd_t want;
            longint     ang_err;
            longint     lin_err;
            longint     turn;
            longint     lin;
            longint     dx;
            longint     dy;
            want = '0;
            if (k == dpba_pkg::KIND_START)
            begin
                ang_integ  = 0;
                dist_integ = 0;
                ang_last   = 0;
                dist_last  = 0;
            end
            else
            begin
                ang_err = -longint'(s);
                lin_err = longint'(d) - longint'(target_dist);
                turn = -pid_update(ang_err, ang_integ, ang_last, ang_gains);
                turn = clamp(turn, longint'(max_ang));
                lin  = pid_update(lin_err, dist_integ, dist_last, lin_gains);
                dx = 0;
                dy = 0;
                case (axis)
                    dpba_pkg::AXIS_POS_X: dx = lin;
                    dpba_pkg::AXIS_NEG_X: dx = -lin;
                    dpba_pkg::AXIS_POS_Y: dy = lin;
                    default:              dy = -lin;
                endcase
                want.dx      = dpba_pkg::DATA_W'(clamp(dx, longint'(max_lin)));
                want.dy      = dpba_pkg::DATA_W'(clamp(dy, longint'(max_lin)));
                want.turn    = dpba_pkg::DATA_W'(turn);
                want.reached = ((lin_err < 0 ? -lin_err : lin_err) < longint'(dist_tol)) &&
                               ((ang_err < 0 ? -ang_err : ang_err) < longint'(slope_tol));
            end
            pending.push_back(want);
        endfunction

        // Compare a delivered command with the oldest pending one
        function void check_result(drive_cmd_t got);
            drive_cmd_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                failed = 1;
                if (mismatches <= 10)
                begin
                    $display("unexpected drive command: dx=%0d dy=%0d turn=%0d reached=%0d",
                             got.dx, got.dy, got.turn, got.reached);
                end
                return;
            end
            want = pending.pop_front();
            if (got.dx !== want.dx || got.dy !== want.dy || got.turn !== want.turn ||
                got.reached !== want.reached)
            begin
                mismatches++;
                failed = 1;
                if (mismatches <= 10)
                begin
                    $display("drive mismatch: expected dx=%0d dy=%0d turn=%0d reached=%0d",
                             want.dx, want.dy, want.turn, want.reached);
                    $display("                actual   dx=%0d dy=%0d turn=%0d reached=%0d",
                             got.dx, got.dy, got.turn, got.reached);
                end
            end
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [dpba_pkg::ADDR_W-1:0]        paddr;
    logic [dpba_pkg::CFG_W-1:0]         pwdata;
    logic [dpba_pkg::CFG_W-1:0]         prdata;
    logic                               pready;
    logic                               in_valid;
    logic                               in_ready;
    logic                               kind;
    logic signed [dpba_pkg::DATA_W-1:0] distance;
    logic signed [dpba_pkg::DATA_W-1:0] slope;
    logic                               out_valid;
    logic                               out_ready;
    logic signed [dpba_pkg::DATA_W-1:0] drive_x;
    logic signed [dpba_pkg::DATA_W-1:0] drive_y;
    logic signed [dpba_pkg::DATA_W-1:0] turn_rate;
    logic                               reached;

    align_scoreboard sb;
    bit              calm;
    bit              hold_req;
    int              idle_cycles;

    dual_pid_base_alignment_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .distance  (distance),
        .slope     (slope),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .drive_x   (drive_x),
        .drive_y   (drive_y),
        .turn_rate (turn_rate),
        .reached   (reached)
    );

    // Clock with period 2
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // End the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles = idle_cycles + 1;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("dual_pid_base_alignment_unit_tb: FAIL");
                    $finish;
                end
            end
        end
    end

    // Accept drive commands with random stalls and one long hold-off
    initial
    begin : receiver
        int stall;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_req)
            begin
                stall    = HOLD_CYCLES;
                hold_req = 0;
            end
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!out_valid);
            sb.check_result('{dx: drive_x, dy: drive_y, turn: turn_rate, reached: reached});
            @(negedge clk);
        end
    end

    // Write one register through the APB port; starts and ends at a falling edge
    task automatic apb_write(dpba_pkg::reg_idx_t idx, logic [dpba_pkg::CFG_W-1:0] v);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = v;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        sb.write_reg(idx, v);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Offer one transaction after a random gap and hold it until accepted
    task automatic send_item(logic k, logic signed [dpba_pkg::DATA_W-1:0] d,
                             logic signed [dpba_pkg::DATA_W-1:0] s);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        kind     = k;
        distance = d;
        slope    = s;
        in_valid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        sb.note_input(k, d, s);
        @(negedge clk);
    endtask

    // Drop valid and wait until every pending command has come out
    task automatic drain();
        in_valid = 1'b0;
        while (sb.pending.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Fill register bits above the width with random junk
    function automatic logic [dpba_pkg::CFG_W-1:0] with_junk(logic [dpba_pkg::CFG_W-1:0] v,
                                                            int w);
        logic [dpba_pkg::CFG_W-1:0] j;
        j = {$urandom, $urandom};
        return (j << w) | v;
    endfunction

    function automatic logic [dpba_pkg::GAINS_W-1:0] rand_gains();
        if ($urandom_range(0, 2) == 0)
        begin
            return dpba_pkg::GAINS_W'({$urandom, $urandom});
        end
        return {16'($urandom_range(0, 8192)), 16'($urandom_range(0, 8192)),
                16'($urandom_range(0, 8192))};
    endfunction

    function automatic logic [dpba_pkg::LIM_W-1:0] rand_limit();
        if ($urandom_range(0, 3) == 0)
        begin
            return dpba_pkg::LIM_W'($urandom_range(0, 32767));
        end
        return dpba_pkg::LIM_W'($urandom_range(100, 2000));
    endfunction

    // Program all registers for a phase: extremes first, then random settings
    task automatic configure(int p);
        logic [dpba_pkg::LIM_W-1:0]   tgt;
        logic [dpba_pkg::GAINS_W-1:0] lg;
        logic [dpba_pkg::GAINS_W-1:0] ag;
        logic [dpba_pkg::LIM_W-1:0]   mxl;
        logic [dpba_pkg::LIM_W-1:0]   mxa;
        logic [dpba_pkg::LIM_W-1:0]   dtol;
        logic [dpba_pkg::LIM_W-1:0]   stol;
        logic [dpba_pkg::CFG_W-1:0]   axv;
        axv = dpba_pkg::CFG_W'(p % 4);
        if (p == 0)
        begin
            tgt  = '1;
            lg   = '1;
            ag   = '1;
            mxl  = '1;
            mxa  = '1;
            dtol = '1;
            stol = '1;
        end
        else if (p == 1)
        begin
            tgt  = '0;
            lg   = '0;
            ag   = '0;
            mxl  = '0;
            mxa  = '0;
            dtol = '0;
            stol = '0;
        end
        else
        begin
            tgt  = ($urandom_range(0, 3) == 0) ? dpba_pkg::LIM_W'($urandom_range(0, 32767))
                                               : dpba_pkg::LIM_W'($urandom_range(0, 1024));
            lg   = rand_gains();
            ag   = rand_gains();
            mxl  = rand_limit();
            mxa  = rand_limit();
            dtol = dpba_pkg::LIM_W'($urandom_range(0, 600));
            stol = dpba_pkg::LIM_W'($urandom_range(0, 600));
        end
        if (p < 2)
        begin
            apb_write(dpba_pkg::REG_TARGET_DISTANCE, dpba_pkg::CFG_W'(tgt));
            apb_write(dpba_pkg::REG_LINEAR_GAINS, dpba_pkg::CFG_W'(lg));
            apb_write(dpba_pkg::REG_ANGULAR_GAINS, dpba_pkg::CFG_W'(ag));
            apb_write(dpba_pkg::REG_MAX_LINEAR, dpba_pkg::CFG_W'(mxl));
            apb_write(dpba_pkg::REG_MAX_ANGULAR, dpba_pkg::CFG_W'(mxa));
            apb_write(dpba_pkg::REG_AXIS_MODE, axv);
            apb_write(dpba_pkg::REG_DISTANCE_TOLERANCE, dpba_pkg::CFG_W'(dtol));
            apb_write(dpba_pkg::REG_SLOPE_TOLERANCE, dpba_pkg::CFG_W'(stol));
        end
        else
        begin
            apb_write(dpba_pkg::REG_TARGET_DISTANCE,
                      with_junk(dpba_pkg::CFG_W'(tgt), dpba_pkg::LIM_W));
            apb_write(dpba_pkg::REG_LINEAR_GAINS,
                      with_junk(dpba_pkg::CFG_W'(lg), dpba_pkg::GAINS_W));
            apb_write(dpba_pkg::REG_ANGULAR_GAINS,
                      with_junk(dpba_pkg::CFG_W'(ag), dpba_pkg::GAINS_W));
            apb_write(dpba_pkg::REG_MAX_LINEAR,
                      with_junk(dpba_pkg::CFG_W'(mxl), dpba_pkg::LIM_W));
            apb_write(dpba_pkg::REG_MAX_ANGULAR,
                      with_junk(dpba_pkg::CFG_W'(mxa), dpba_pkg::LIM_W));
            apb_write(dpba_pkg::REG_AXIS_MODE, with_junk(axv, 2));
            apb_write(dpba_pkg::REG_DISTANCE_TOLERANCE,
                      with_junk(dpba_pkg::CFG_W'(dtol), dpba_pkg::LIM_W));
            apb_write(dpba_pkg::REG_SLOPE_TOLERANCE,
                      with_junk(dpba_pkg::CFG_W'(stol), dpba_pkg::LIM_W));
        end
    endtask

    // Random goals: measurements, half of them near the target, with starts mixed in at random
    task automatic run_burst(int n, bit pressure);
        int   i;
        int   di;
        int   si;
        logic k;
        for (i = 0; i < n; i++)
        begin
            if (i % 25 == 0)
            begin
                calm = ($urandom_range(0, 3) == 0) || (pressure && i == 0);
            end
            k = ($urandom_range(0, 11) == 0) ? dpba_pkg::KIND_START : dpba_pkg::KIND_MEASURE;
            case ($urandom_range(0, 3))
                0, 1:
                begin
                    di = int'(sb.target_dist) + int'($urandom_range(0, 600)) - 300;
                    si = int'($urandom_range(0, 600)) - 300;
                end
                2:
                begin
                    di = $urandom;
                    si = $urandom;
                end
                default:
                begin
                    di = $urandom_range(0, 1) ? 32767 : -32768;
                    si = $urandom_range(0, 1) ? 32767 : -32768;
                end
            endcase
            send_item(k, di[dpba_pkg::DATA_W-1:0], si[dpba_pkg::DATA_W-1:0]);
        end
    endtask

    // Main sequence: reset, directed goals, then configured random phases
    initial
    begin
        int p;
        sb          = new();
        calm        = 0;
        hold_req    = 0;
        idle_cycles = 0;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        kind        = dpba_pkg::KIND_START;
        distance    = '0;
        slope       = '0;
        out_ready   = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed goals under the reset settings
        send_item(dpba_pkg::KIND_START, 16'sh7FFF, -16'sh8000);
        send_item(dpba_pkg::KIND_MEASURE, 16'sd205, 16'sd0);
        send_item(dpba_pkg::KIND_MEASURE, 16'sd368, 16'sd163);
        send_item(dpba_pkg::KIND_MEASURE, 16'sd369, 16'sd0);
        send_item(dpba_pkg::KIND_MEASURE, 16'sd41, -16'sd163);
        send_item(dpba_pkg::KIND_MEASURE, 16'sd205, -16'sd164);
        send_item(dpba_pkg::KIND_MEASURE, 16'sd205, 16'sd1);
        send_item(dpba_pkg::KIND_MEASURE, 16'sd205, -16'sd1);
        send_item(dpba_pkg::KIND_MEASURE, 16'sh7FFF, -16'sh8000);
        send_item(dpba_pkg::KIND_MEASURE, 16'sh7FFF, -16'sh8000);
        send_item(dpba_pkg::KIND_MEASURE, -16'sh8000, 16'sh7FFF);
        send_item(dpba_pkg::KIND_MEASURE, -16'sh8000, 16'sh7FFF);
        send_item(dpba_pkg::KIND_MEASURE, 16'sd0, 16'sd0);
        send_item(dpba_pkg::KIND_MEASURE, -16'sd1, -16'sd1);
        send_item(dpba_pkg::KIND_START, 16'sd0, 16'sd0);
        send_item(dpba_pkg::KIND_MEASURE, -16'sh8000, -16'sh8000);
        send_item(dpba_pkg::KIND_MEASURE, 16'sd300, 16'sd100);
        send_item(dpba_pkg::KIND_MEASURE, 16'sd150, -16'sd50);
        send_item(dpba_pkg::KIND_START, -16'sd1, 16'sd1);
        send_item(dpba_pkg::KIND_MEASURE, 16'sd205, 16'sd0);
        drain();

        // Configured phases; the third one carries the long receiver hold-off
        for (p = 0; p < NUM_PHASES; p++)
        begin
            configure(p);
            send_item(dpba_pkg::KIND_START, 16'sd0, 16'sd0);
            if (p == 2)
            begin
                hold_req = 1;
            end
            run_burst(BURST_LEN, p == 2);
            drain();
        end

        if (!sb.failed && sb.pending.size() == 0)
        begin
            $display("dual_pid_base_alignment_unit_tb: PASS");
        end
        else
        begin
            $display("dual_pid_base_alignment_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
